@@ sv/btok_pkg.sv @@
// btok_pkg: shared types, constants and byte-class helpers for the byte stream tokenizer.
// No dependencies; every other file imports it.
`timescale 1ns / 1ps
`default_nettype none

package btok_pkg;

  localparam int BYTE_W        = 8;
  localparam int KIND_W        = 4;
  localparam int VALUE_W       = 63;
  localparam int POS_WIDTH_DEF = 16;
  localparam int QUEUE_DEPTH   = 4;

  typedef enum logic [KIND_W-1:0] {
    TK_LET     = 4'd0,
    TK_PRINT   = 4'd1,
    TK_IDENT   = 4'd2,
    TK_INT     = 4'd3,
    TK_ASSIGN  = 4'd4,
    TK_PLUS    = 4'd5,
    TK_MINUS   = 4'd6,
    TK_SEMI    = 4'd7,
    TK_LPAREN  = 4'd8,
    TK_RPAREN  = 4'd9,
    TK_END     = 4'd10,
    TK_UNKNOWN = 4'd11
  } token_kind_e;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_IDENT   = 3'd1,
    MODE_NUMBER  = 3'd2,
    MODE_SLASH   = 3'd3,
    MODE_COMMENT = 3'd4
  } scan_mode_e;

  localparam logic [BYTE_W-1:0] CH_SLASH   = 8'h2F;
  localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_UNDER   = 8'h5F;
  localparam logic [BYTE_W-1:0] CH_EQUAL   = 8'h3D;
  localparam logic [BYTE_W-1:0] CH_PLUS    = 8'h2B;
  localparam logic [BYTE_W-1:0] CH_MINUS   = 8'h2D;
  localparam logic [BYTE_W-1:0] CH_SEMI    = 8'h3B;
  localparam logic [BYTE_W-1:0] CH_LPAREN  = 8'h28;
  localparam logic [BYTE_W-1:0] CH_RPAREN  = 8'h29;
  localparam logic [BYTE_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [BYTE_W-1:0] CH_TAB     = 8'h09;
  localparam logic [BYTE_W-1:0] CH_CR      = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE    = 8'h39;
  // keyword letters
  localparam logic [BYTE_W-1:0] CH_L = 8'h6C;
  localparam logic [BYTE_W-1:0] CH_E = 8'h65;
  localparam logic [BYTE_W-1:0] CH_T = 8'h74;
  localparam logic [BYTE_W-1:0] CH_P = 8'h70;
  localparam logic [BYTE_W-1:0] CH_R = 8'h72;
  localparam logic [BYTE_W-1:0] CH_I = 8'h69;
  localparam logic [BYTE_W-1:0] CH_N = 8'h6E;

  function automatic logic is_letter(input logic [BYTE_W-1:0] b);
    return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A) || (b == CH_UNDER);
  endfunction

  function automatic logic is_digit(input logic [BYTE_W-1:0] b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

  function automatic logic is_space(input logic [BYTE_W-1:0] b);
    return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
  endfunction

  function automatic token_kind_e single_char_kind(input logic [BYTE_W-1:0] b);
    token_kind_e k;
    unique case (b)
      CH_EQUAL:  k = TK_ASSIGN;
      CH_PLUS:   k = TK_PLUS;
      CH_MINUS:  k = TK_MINUS;
      CH_SEMI:   k = TK_SEMI;
      CH_LPAREN: k = TK_LPAREN;
      CH_RPAREN: k = TK_RPAREN;
      default:   k = TK_UNKNOWN;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

@@ sv/btok_in_if.sv @@
// btok_in_if: valid/ready channel carrying one source byte per transaction.
// Depends on btok_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface btok_in_if import btok_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] text_byte;
  logic              finish;

  modport source (output valid, output text_byte, output finish, input ready);
  modport sink   (input valid, input text_byte, input finish, output ready);
endinterface

`default_nettype wire

@@ sv/btok_out_if.sv @@
// btok_out_if: valid/ready channel carrying one token per transaction.
// Depends on btok_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface btok_out_if import btok_pkg::*; #(
  parameter int POS_WIDTH = POS_WIDTH_DEF
) ();
  logic                 valid;
  logic                 ready;
  logic [KIND_W-1:0]    token_kind;
  logic [VALUE_W-1:0]   int_value;
  logic [POS_WIDTH-1:0] start_pos;
  logic [POS_WIDTH-1:0] token_length;
  logic                 last_of_run;

  modport source (output valid, output token_kind, output int_value, output start_pos,
                  output token_length, output last_of_run, input ready);
  modport sink   (input valid, input token_kind, input int_value, input start_pos,
                  input token_length, input last_of_run, output ready);
endinterface

`default_nettype wire

@@ sv/btok_scan.sv @@
// btok_scan: front end. Accepts bytes, runs the scanner state and packs the
// zero, one or two tokens a byte produces into one queue entry. Depends on btok_pkg.
`timescale 1ns / 1ps
`default_nettype none

module btok_scan import btok_pkg::*; #(
  parameter int POS_WIDTH = POS_WIDTH_DEF,
  parameter int ENTRY_W   = 2 * KIND_W + VALUE_W + 4 * POS_WIDTH + 1
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  btok_in_if.sink                 in_i,
  input  wire logic               q_full_i,
  output logic                    q_push_o,
  output logic [ENTRY_W-1:0]      q_data_o
);

  localparam int SUM_W = VALUE_W + 4;
  localparam logic [POS_WIDTH-1:0] POS_MAX = {POS_WIDTH{1'b1}};
  localparam logic [POS_WIDTH-1:0] LEN_ONE = POS_WIDTH'(1);

  scan_mode_e            mode_q, mode_d;
  logic [VALUE_W-1:0]    accum_q, accum_d;
  logic                  ovf_q, ovf_d;
  logic [POS_WIDTH-1:0]  start_q, start_d;
  logic [POS_WIDTH-1:0]  len_q, len_d;
  logic                  let_q, let_d;
  logic                  print_q, print_d;
  logic [POS_WIDTH-1:0]  pos_q, pos_d;

  logic [BYTE_W-1:0]     b;
  logic                  accept, eoi, restart, use_flush;
  logic [SUM_W-1:0]      num_sum;
  logic [POS_WIDTH-1:0]  len_inc, pos_inc;

  logic                  flush_v;
  token_kind_e           flush_kind;
  logic [VALUE_W-1:0]    flush_val;
  logic                  sec_v;
  token_kind_e           sec_kind;
  logic [POS_WIDTH-1:0]  sec_len;

  token_kind_e           k0, k1;
  logic [VALUE_W-1:0]    v0;
  logic [POS_WIDTH-1:0]  s0, l0, s1, l1;
  logic                  two;

  assign b         = in_i.text_byte;
  assign in_i.ready = !q_full_i;
  assign accept    = in_i.valid && !q_full_i;
  assign eoi       = in_i.finish || (b == '0);

  // acc*10 + digit; anything above the low 63 bits is overflow
  assign num_sum = ({4'b0, accum_q} << 3) + ({4'b0, accum_q} << 1)
                 + SUM_W'(b[3:0]);
  assign len_inc = (len_q == POS_MAX) ? len_q : len_q + LEN_ONE;
  assign pos_inc = (pos_q == POS_MAX) ? pos_q : pos_q + LEN_ONE;

  // token still open from earlier bytes
  always_comb begin
    flush_v    = 1'b0;
    flush_kind = TK_IDENT;
    flush_val  = '0;
    unique case (mode_q)
      MODE_IDENT: begin
        flush_v = 1'b1;
        if (let_q && len_q == POS_WIDTH'(3)) flush_kind = TK_LET;
        else if (print_q && len_q == POS_WIDTH'(5)) flush_kind = TK_PRINT;
        else flush_kind = TK_IDENT;
      end
      MODE_NUMBER: begin
        flush_v    = 1'b1;
        flush_kind = TK_INT;
        flush_val  = ovf_q ? '0 : accum_q;
      end
      MODE_SLASH: begin
        flush_v    = 1'b1;
        flush_kind = TK_UNKNOWN;
      end
      default: begin
        flush_v = 1'b0;
      end
    endcase
  end

  always_comb begin
    mode_d    = mode_q;
    accum_d   = accum_q;
    ovf_d     = ovf_q;
    start_d   = start_q;
    len_d     = len_q;
    let_d     = let_q;
    print_d   = print_q;
    pos_d     = pos_q;
    restart   = 1'b0;
    use_flush = 1'b0;
    sec_v     = 1'b0;
    sec_kind  = TK_UNKNOWN;
    sec_len   = LEN_ONE;

    if (accept) begin
      pos_d = pos_inc;
      if (eoi) begin
        use_flush = flush_v;
        sec_v     = 1'b1;
        sec_kind  = TK_END;
        sec_len   = '0;
        mode_d    = MODE_IDLE;
        accum_d   = '0;
        ovf_d     = 1'b0;
        start_d   = '0;
        len_d     = '0;
        let_d     = 1'b0;
        print_d   = 1'b0;
        pos_d     = '0;
      end else begin
        unique case (mode_q)
          MODE_IDENT: begin
            if (is_letter(b) || is_digit(b)) begin
              let_d   = let_q && ((len_q == POS_WIDTH'(1) && b == CH_E) ||
                                  (len_q == POS_WIDTH'(2) && b == CH_T));
              print_d = print_q && ((len_q == POS_WIDTH'(1) && b == CH_R) ||
                                    (len_q == POS_WIDTH'(2) && b == CH_I) ||
                                    (len_q == POS_WIDTH'(3) && b == CH_N) ||
                                    (len_q == POS_WIDTH'(4) && b == CH_T));
              len_d   = len_inc;
            end else begin
              restart = 1'b1;
            end
          end
          MODE_NUMBER: begin
            if (is_digit(b)) begin
              if (!ovf_q) begin
                if (|num_sum[SUM_W-1:VALUE_W]) ovf_d = 1'b1;
                else accum_d = num_sum[VALUE_W-1:0];
              end
              len_d = len_inc;
            end else begin
              restart = 1'b1;
            end
          end
          MODE_SLASH: begin
            if (b == CH_SLASH) mode_d = MODE_COMMENT;
            else restart = 1'b1;
          end
          MODE_COMMENT: begin
            if (b == CH_NEWLINE) mode_d = MODE_IDLE;
          end
          default: begin
            restart = 1'b1;
          end
        endcase

        if (restart) begin
          use_flush = flush_v;
          mode_d    = MODE_IDLE;
          if (is_space(b)) begin
            mode_d = MODE_IDLE;
          end else if (b == CH_SLASH) begin
            mode_d  = MODE_SLASH;
            start_d = pos_q;
            len_d   = LEN_ONE;
          end else if (is_letter(b)) begin
            mode_d  = MODE_IDENT;
            start_d = pos_q;
            len_d   = LEN_ONE;
            let_d   = (b == CH_L);
            print_d = (b == CH_P);
          end else if (is_digit(b)) begin
            mode_d  = MODE_NUMBER;
            start_d = pos_q;
            len_d   = LEN_ONE;
            accum_d = VALUE_W'(b[3:0]);
            ovf_d   = 1'b0;
          end else begin
            sec_v    = 1'b1;
            sec_kind = single_char_kind(b);
          end
        end
      end
    end
  end

  // pack: the second slot only ever holds a value-less token
  always_comb begin
    if (use_flush) begin
      k0  = flush_kind;
      v0  = flush_val;
      s0  = start_q;
      l0  = (mode_q == MODE_SLASH) ? LEN_ONE : len_q;
      two = sec_v;
    end else begin
      k0  = sec_kind;
      v0  = '0;
      s0  = pos_q;
      l0  = sec_len;
      two = 1'b0;
    end
    k1 = sec_kind;
    s1 = pos_q;
    l1 = sec_len;
  end

  assign q_push_o = use_flush || sec_v;
  assign q_data_o = {two, k0, v0, s0, l0, k1, s1, l1};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      accum_q <= '0;
      ovf_q   <= 1'b0;
      start_q <= '0;
      len_q   <= '0;
      let_q   <= 1'b0;
      print_q <= 1'b0;
      pos_q   <= '0;
    end else begin
      mode_q  <= mode_d;
      accum_q <= accum_d;
      ovf_q   <= ovf_d;
      start_q <= start_d;
      len_q   <= len_d;
      let_q   <= let_d;
      print_q <= print_d;
      pos_q   <= pos_d;
    end
  end

endmodule

`default_nettype wire

@@ sv/btok_queue.sv @@
// btok_queue: small flop-based FIFO between scanner and token emitter.
// Depends on btok_pkg for the default depth.
`timescale 1ns / 1ps
`default_nettype none

module btok_queue import btok_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      data_o,
  output logic                  empty_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) wptr_d = (wptr_q == LAST) ? '0 : wptr_q + AW'(1);
    if (do_pop)  rptr_d = (rptr_q == LAST) ? '0 : rptr_q + AW'(1);
    if (do_push && !do_pop) cnt_d = cnt_q + CW'(1);
    else if (do_pop && !do_push) cnt_d = cnt_q - CW'(1);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wptr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

`default_nettype wire

@@ sv/btok_emit.sv @@
// btok_emit: back end. Unpacks queue entries into single tokens and drives the
// registered output channel, flagging the last token of each run. Depends on btok_pkg.
`timescale 1ns / 1ps
`default_nettype none

module btok_emit import btok_pkg::*; #(
  parameter int POS_WIDTH = POS_WIDTH_DEF,
  parameter int ENTRY_W   = 2 * KIND_W + VALUE_W + 4 * POS_WIDTH + 1
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               q_empty_i,
  input  wire logic [ENTRY_W-1:0] q_data_i,
  output logic                    q_pop_o,
  btok_out_if.source              out_o
);

  logic                 e_two;
  logic [KIND_W-1:0]    e_k0, e_k1;
  logic [VALUE_W-1:0]   e_v0;
  logic [POS_WIDTH-1:0] e_s0, e_l0, e_s1, e_l1;

  logic                 sub_q, sub_d;
  logic                 vld_q, vld_d;
  logic [KIND_W-1:0]    kind_q, kind_d;
  logic [VALUE_W-1:0]   val_q, val_d;
  logic [POS_WIDTH-1:0] start_q, start_d;
  logic [POS_WIDTH-1:0] len_q, len_d;
  logic                 last_q, last_d;
  logic                 load;

  assign {e_two, e_k0, e_v0, e_s0, e_l0, e_k1, e_s1, e_l1} = q_data_i;

  assign load = !q_empty_i && (!vld_q || out_o.ready);

  always_comb begin
    sub_d   = sub_q;
    vld_d   = vld_q && !out_o.ready;
    kind_d  = kind_q;
    val_d   = val_q;
    start_d = start_q;
    len_d   = len_q;
    last_d  = last_q;
    q_pop_o = 1'b0;
    if (load) begin
      vld_d = 1'b1;
      if (!sub_q) begin
        kind_d  = e_k0;
        val_d   = e_v0;
        start_d = e_s0;
        len_d   = e_l0;
        last_d  = !e_two;
        sub_d   = e_two;
        q_pop_o = !e_two;
      end else begin
        kind_d  = e_k1;
        val_d   = '0;
        start_d = e_s1;
        len_d   = e_l1;
        last_d  = 1'b1;
        sub_d   = 1'b0;
        q_pop_o = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sub_q <= 1'b0;
      vld_q <= 1'b0;
    end else begin
      sub_q <= sub_d;
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;
    val_q   <= val_d;
    start_q <= start_d;
    len_q   <= len_d;
    last_q  <= last_d;
  end

  assign out_o.valid        = vld_q;
  assign out_o.token_kind   = kind_q;
  assign out_o.int_value    = val_q;
  assign out_o.start_pos    = start_q;
  assign out_o.token_length = len_q;
  assign out_o.last_of_run  = last_q;

endmodule

`default_nettype wire

@@ sv/byte_stream_tokenizer_top.sv @@
// byte_stream_tokenizer_top: scanner front end, entry queue, token emitter.
// Throughput: one byte per cycle while the queue is not full; one token leaves per cycle
// while the output is ready, and a two-token byte holds its entry until both have left;
// input stalls while the queue is full. Path: a byte's tokens go into a queue entry, then
// the output register; the second token of a two-token byte loads once the first is taken.
// Reset: asynchronous, active low; clears scanner state, queue and output valid.
`timescale 1ns / 1ps
`default_nettype none

module byte_stream_tokenizer_top import btok_pkg::*; #(
  parameter int POS_WIDTH = POS_WIDTH_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  btok_in_if.sink         in_i,
  btok_out_if.source      out_o
);

  localparam int ENTRY_W = 2 * KIND_W + VALUE_W + 4 * POS_WIDTH + 1;

  logic               q_push, q_full, q_pop, q_empty;
  logic [ENTRY_W-1:0] q_wdata, q_rdata;

  btok_scan #(
    .POS_WIDTH (POS_WIDTH),
    .ENTRY_W   (ENTRY_W)
  ) u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_data_o (q_wdata)
  );

  btok_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_rdata),
    .empty_o (q_empty)
  );

  btok_emit #(
    .POS_WIDTH (POS_WIDTH),
    .ENTRY_W   (ENTRY_W)
  ) u_emit (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_data_i  (q_rdata),
    .q_pop_o   (q_pop),
    .out_o     (out_o)
  );

`ifndef NO_ASSERTIONS
  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_push && q_full))
    else $error("scanner pushed into a full queue");

  a_pop_needs_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("emitter popped an empty queue");

  a_end_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.token_kind == TK_END) |->
      (out_o.token_length == '0 && out_o.last_of_run))
    else $error("END token must have zero length and close its run");

  a_value_only_int: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.int_value != '0) |-> out_o.token_kind == TK_INT)
    else $error("nonzero value on a non-integer token");
`endif

endmodule

`default_nettype wire
